// ----- rtl/sdspi_pkg.sv -----
// ----------------------------------------------------------------------------
// sdspi_pkg
// shared widths, protocol constants and the crc7 byte update for the
// sd spi command engine
// ----------------------------------------------------------------------------
package sdspi_pkg;

    localparam int unsigned POLL_LIMIT = 4096;
    localparam int unsigned POLL_W     = $clog2(POLL_LIMIT + 1);

    localparam int unsigned CMD_IDX_W  = 6;
    localparam int unsigned ARG_W      = 32;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned RETRY_W    = 4;
    localparam int unsigned FRAME_W    = BYTE_W + ARG_W;

    localparam logic [RETRY_W-1:0] RETRY_RESET = 4'd10;

    localparam logic [BYTE_W-1:0] CMD_BASE  = 8'h40;
    localparam logic [BYTE_W-1:0] IDLE_BYTE = 8'hFF;
    localparam logic [6:0]        CRC7_POLY = 7'h09;

    // r1 response bit positions
    localparam int unsigned R1_BUSY_BIT    = 7;
    localparam int unsigned R1_CRC_ERR_BIT = 3;

    // operation codes of the request channel
    localparam logic OP_ISSUE = 1'b0;
    localparam logic OP_POLL  = 1'b1;

    // crc7 over one byte, msb first
    function automatic logic [6:0] crc7_byte(input logic [6:0] crc_in,
                                             input logic [BYTE_W-1:0] data);
        logic [6:0] c;
        logic       fb;
        c = crc_in;
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            fb = c[6] ^ data[i];
            c  = {c[5:0], 1'b0};
            if (fb)
            begin
                c = c ^ CRC7_POLY;
            end
        end
        return c;
    endfunction

endpackage

// ----- rtl/sdspi_if.sv -----
// ----------------------------------------------------------------------------
// sdspi channel interfaces
// request channel (issue or poll byte) and result channel (one byte exchange
// or a completion status), each with valid and ready
// ----------------------------------------------------------------------------
interface sdspi_req_if import sdspi_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 operation;
    logic [CMD_IDX_W-1:0] command_index;
    logic [ARG_W-1:0]     argument;
    logic                 release_after;
    logic [BYTE_W-1:0]    received_byte;

    modport source (
        output valid, operation, command_index, argument, release_after,
               received_byte,
        input  ready
    );

    modport sink (
        input  valid, operation, command_index, argument, release_after,
               received_byte,
        output ready
    );
endinterface

interface sdspi_rsp_if import sdspi_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] tx_byte;
    logic              select_active;
    logic              expect_reply;
    logic              last;
    logic              done_res;
    logic [BYTE_W-1:0] response;
    logic              timed_out;

    modport source (
        output valid, tx_byte, select_active, expect_reply, last, done_res,
               response, timed_out,
        input  ready
    );

    modport sink (
        input  valid, tx_byte, select_active, expect_reply, last, done_res,
               response, timed_out,
        output ready
    );
endinterface

// ----- rtl/sd_spi_command_engine_top.sv -----
// ----------------------------------------------------------------------------
// sd_spi_command_engine_top
// host side sd card command sequencer for spi mode, with crc7 framing,
// response polling and crc error retries
// ----------------------------------------------------------------------------
// Each request transfer is either an issue (command index, argument, release
// flag) or the byte received on the last poll exchange. The engine answers
// with a burst of result transfers, one per spi byte exchange, the final one
// flagged by last: an issue gives the six frame bytes and a first 0xff poll;
// a busy poll byte gives one more poll; a final response gives a completion
// status, preceded by a deselect byte when release is set; a crc error under
// release with retries left gives a deselect byte, frame and poll. Results
// leave through an output register at one per cycle while the sink keeps
// ready high; an item gives 0 to 8 results, and the next request is taken
// in the cycle its predecessor's last result is loaded. Poll bytes arriving
// while no command runs are dropped silently. The crc7 is built one byte
// per cycle as the frame goes out, held while the sink stalls. retry_limit
// (reset 10, zero counts as one attempt) may only be written while idle.
// ----------------------------------------------------------------------------
module sd_spi_command_engine_top import sdspi_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [RETRY_W-1:0] cfg_wdata,
    sdspi_req_if.sink          req,
    sdspi_rsp_if.source        rsp
);

    // position inside a result burst
    typedef enum logic [3:0] {
        STEP_REL,
        STEP_B0,
        STEP_B1,
        STEP_B2,
        STEP_B3,
        STEP_B4,
        STEP_CRC,
        STEP_POLL,
        STEP_DONE
    } step_t;

    // command state
    logic [RETRY_W-1:0] retry_limit_reg;
    logic [RETRY_W-1:0] attempt_reg,  attempt_next;
    logic [POLL_W-1:0]  poll_cnt_reg, poll_cnt_next;
    logic               release_reg,  release_next;
    logic               busy_reg,     busy_next;
    logic [FRAME_W-1:0] frame_reg,    frame_next;
    logic [6:0]         crc_reg,      crc_next;

    // burst sequencer
    logic               job_active_reg, job_active_next;
    step_t              step_reg,       step_next;
    logic               rel_done_reg,   rel_done_next;
    logic [BYTE_W-1:0]  done_resp_reg,  done_resp_next;
    logic               done_sel_reg,   done_sel_next;

    // output register
    logic               out_valid_reg;
    logic [BYTE_W-1:0]  out_tx_reg;
    logic               out_sel_reg;
    logic               out_exp_reg;
    logic               out_last_reg;
    logic               out_done_reg;
    logic [BYTE_W-1:0]  out_resp_reg;
    logic               out_to_reg;

    logic               out_load;
    logic               step_last;
    logic               in_fire;
    logic [BYTE_W-1:0]  frame_byte;
    logic [BYTE_W-1:0]  rx_byte;
    logic [RETRY_W-1:0] lim;
    logic               retry_ok;

    // result register takes a new entry when empty or being drained
    assign out_load  = job_active_reg && (!out_valid_reg || rsp.ready);
    assign step_last = (step_reg == STEP_POLL) || (step_reg == STEP_DONE);

    // next request is taken as the current burst hands over its last result
    assign req.ready = !job_active_reg || (out_load && step_last);
    assign in_fire   = req.valid && req.ready;

    assign rx_byte  = req.received_byte;
    assign lim      = (retry_limit_reg == '0) ? RETRY_W'(1) : retry_limit_reg;
    assign retry_ok = rx_byte[R1_CRC_ERR_BIT] &&
                      (({1'b0, attempt_reg} + (RETRY_W + 1)'(1)) < {1'b0, lim});

    // frame byte for the current step, cmd byte first
    always_comb
    begin
        unique case (step_reg)
            STEP_B0: frame_byte = frame_reg[FRAME_W-1 -: BYTE_W];
            STEP_B1: frame_byte = frame_reg[FRAME_W-1-BYTE_W -: BYTE_W];
            STEP_B2: frame_byte = frame_reg[FRAME_W-1-2*BYTE_W -: BYTE_W];
            STEP_B3: frame_byte = frame_reg[FRAME_W-1-3*BYTE_W -: BYTE_W];
            STEP_B4: frame_byte = frame_reg[BYTE_W-1:0];
            default: frame_byte = frame_reg[BYTE_W-1:0];
        endcase
    end

    // running crc7, restarted on the command byte
    always_comb
    begin
        crc_next = crc_reg;
        if (out_load &&
            (step_reg == STEP_B0 || step_reg == STEP_B1 || step_reg == STEP_B2 ||
             step_reg == STEP_B3 || step_reg == STEP_B4))
        begin
            crc_next = crc7_byte((step_reg == STEP_B0) ? 7'd0 : crc_reg, frame_byte);
        end
    end

    // command state update and burst setup on each accepted request
    always_comb
    begin
        attempt_next    = attempt_reg;
        poll_cnt_next   = poll_cnt_reg;
        release_next    = release_reg;
        busy_next       = busy_reg;
        frame_next      = frame_reg;
        rel_done_next   = rel_done_reg;
        done_resp_next  = done_resp_reg;
        done_sel_next   = done_sel_reg;
        job_active_next = job_active_reg;
        step_next       = step_reg;

        // advance the running burst
        if (out_load)
        begin
            unique case (step_reg)
                STEP_REL:  step_next = rel_done_reg ? STEP_DONE : STEP_B0;
                STEP_B0:   step_next = STEP_B1;
                STEP_B1:   step_next = STEP_B2;
                STEP_B2:   step_next = STEP_B3;
                STEP_B3:   step_next = STEP_B4;
                STEP_B4:   step_next = STEP_CRC;
                STEP_CRC:  step_next = STEP_POLL;
                STEP_POLL: job_active_next = 1'b0;
                STEP_DONE: job_active_next = 1'b0;
                default:   job_active_next = 1'b0;
            endcase
        end

        if (in_fire)
        begin
            priority if (req.operation == OP_ISSUE)
            begin
                // a new issue abandons any running command
                frame_next      = {CMD_BASE + {2'b00, req.command_index}, req.argument};
                release_next    = req.release_after;
                attempt_next    = '0;
                busy_next       = 1'b1;
                poll_cnt_next   = POLL_W'(1);
                job_active_next = 1'b1;
                step_next       = STEP_B0;
            end
            else if (!busy_reg)
            begin
                // stray poll byte, no results
            end
            else if (rx_byte[R1_BUSY_BIT] && (poll_cnt_reg < POLL_W'(POLL_LIMIT)))
            begin
                poll_cnt_next   = poll_cnt_reg + POLL_W'(1);
                job_active_next = 1'b1;
                step_next       = STEP_POLL;
            end
            else if (release_reg)
            begin
                job_active_next = 1'b1;
                step_next       = STEP_REL;
                if (retry_ok)
                begin
                    // resend the same frame
                    attempt_next  = attempt_reg + RETRY_W'(1);
                    poll_cnt_next = POLL_W'(1);
                    rel_done_next = 1'b0;
                end
                else
                begin
                    if (rx_byte[R1_CRC_ERR_BIT])
                    begin
                        attempt_next = attempt_reg + RETRY_W'(1);
                    end
                    busy_next      = 1'b0;
                    rel_done_next  = 1'b1;
                    done_resp_next = rx_byte;
                    done_sel_next  = 1'b0;
                end
            end
            else
            begin
                // card stays selected
                busy_next       = 1'b0;
                job_active_next = 1'b1;
                step_next       = STEP_DONE;
                done_resp_next  = rx_byte;
                done_sel_next   = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_limit_reg <= RETRY_RESET;
            attempt_reg     <= '0;
            poll_cnt_reg    <= '0;
            release_reg     <= 1'b0;
            busy_reg        <= 1'b0;
            job_active_reg  <= 1'b0;
            step_reg        <= STEP_REL;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                retry_limit_reg <= cfg_wdata;
            end
            attempt_reg    <= attempt_next;
            poll_cnt_reg   <= poll_cnt_next;
            release_reg    <= release_next;
            busy_reg       <= busy_next;
            job_active_reg <= job_active_next;
            step_reg       <= step_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        frame_reg     <= frame_next;
        crc_reg       <= crc_next;
        rel_done_reg  <= rel_done_next;
        done_resp_reg <= done_resp_next;
        done_sel_reg  <= done_sel_next;
        if (out_load)
        begin
            out_last_reg <= step_last;
            out_done_reg <= (step_reg == STEP_DONE);
            out_resp_reg <= (step_reg == STEP_DONE) ? done_resp_reg : '0;
            out_to_reg   <= (step_reg == STEP_DONE) && done_resp_reg[R1_BUSY_BIT];
            out_exp_reg  <= (step_reg == STEP_POLL);
            unique case (step_reg)
                STEP_REL:
                begin
                    out_tx_reg  <= IDLE_BYTE;
                    out_sel_reg <= 1'b0;
                end
                STEP_CRC:
                begin
                    out_tx_reg  <= {crc_reg, 1'b1};
                    out_sel_reg <= 1'b1;
                end
                STEP_POLL:
                begin
                    out_tx_reg  <= IDLE_BYTE;
                    out_sel_reg <= 1'b1;
                end
                STEP_DONE:
                begin
                    out_tx_reg  <= '0;
                    out_sel_reg <= done_sel_reg;
                end
                default:
                begin
                    out_tx_reg  <= frame_byte;
                    out_sel_reg <= 1'b1;
                end
            endcase
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.tx_byte       = out_tx_reg;
    assign rsp.select_active = out_sel_reg;
    assign rsp.expect_reply  = out_exp_reg;
    assign rsp.last          = out_last_reg;
    assign rsp.done_res      = out_done_reg;
    assign rsp.response      = out_resp_reg;
    assign rsp.timed_out     = out_to_reg;

`ifndef ASSERT_OFF
    // poll counter never runs past the limit
    a_poll_bound: assert property (@(posedge clk) disable iff (!rst_n)
        poll_cnt_reg <= POLL_W'(POLL_LIMIT))
        else $error("poll count beyond limit");

    // an issue starts a burst on the command byte
    a_issue_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && req.operation == OP_ISSUE) |=> (job_active_reg && step_reg == STEP_B0))
        else $error("issue did not start frame");

    // the crc byte always carries the stop bit
    a_crc_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && step_reg == STEP_CRC) |=> (rsp.valid && rsp.tx_byte[0]))
        else $error("crc byte without stop bit");

    // a completion status closes its burst and needs no reply
    a_done_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.done_res) |-> (rsp.last && !rsp.expect_reply))
        else $error("malformed completion status");
`endif

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the sd spi command engine: a cycle-free model of
// the command framing, crc7, response polling and crc retry rules predicts
// every result transfer, and a monitor compares the result channel against
// it under random source gaps and sink stalls
// ----------------------------------------------------------------------------
module tb_top;
    import sdspi_pkg::*;

    // watchdog, well above the slowest legal run: about 500 items, each
    // with up to 8 result transfers behind sink stalls and a source gap
    localparam int unsigned CYCLE_LIMIT   = 300_000;
    // idle cycles allowed after the last expected transfer before a
    // register write or the end of the run
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned REPORT_MAX    = 10;
    localparam int unsigned RANDOM_ITEMS  = 340;
    localparam int unsigned FULL_RATE_ITEMS = 50;

    // one request as the host presents it
    typedef struct packed {
        logic                 operation;
        logic [CMD_IDX_W-1:0] command_index;
        logic [ARG_W-1:0]     argument;
        logic                 release_after;
        logic [BYTE_W-1:0]    received_byte;
    } host_req_t;

    // one result transfer: a byte exchange or a completion status
    typedef struct packed {
        logic [BYTE_W-1:0] tx_byte;
        logic              select_active;
        logic              expect_reply;
        logic              last;
        logic              done_res;
        logic [BYTE_W-1:0] response;
        logic              timed_out;
    } exch_t;

    logic clk;
    logic rst_n;
    logic               cfg_we;
    logic [RETRY_W-1:0] cfg_wdata;

    sdspi_req_if req ();
    sdspi_rsp_if rsp ();

    sd_spi_command_engine_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req.sink),
        .rsp       (rsp.source)
    );

    // ------------------------------------------------------------------
    // engine state as the bench tracks it
    // ------------------------------------------------------------------
    logic [RETRY_W-1:0]  m_retry_limit;
    logic [47:0]         m_frame;       // cmd byte, argument, crc byte
    logic [RETRY_W-1:0]  m_attempts;
    int unsigned         m_polls;
    logic                m_release;
    logic                m_busy;

    // result transfers still owed by the engine, oldest first
    exch_t pending_exch[$];

    int unsigned mismatches;
    int unsigned taken_items;   // accepted items that caused any transfer
    int unsigned cycle_count;
    bit          gaps_on;       // random idling on both channels

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // crc7, x^7 + x^3 + 1, data msb first
    function automatic logic [6:0] crc7_next(input logic [6:0] crc,
                                             input logic [BYTE_W-1:0] data);
        logic [6:0] c;
        c = crc;
        for (int k = BYTE_W - 1; k >= 0; k--)
        begin
            if (c[6] != data[k])
            begin
                c = {c[5:0], 1'b0} ^ CRC7_POLY;
            end
            else
            begin
                c = {c[5:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic exch_t mk_exch(input logic [BYTE_W-1:0] tx, input logic sel,
                                      input logic rep, input logic done,
                                      input logic [BYTE_W-1:0] resp,
                                      input logic tmo);
        exch_t e;
        e.tx_byte       = tx;
        e.select_active = sel;
        e.expect_reply  = rep;
        e.last          = 1'b0;
        e.done_res      = done;
        e.response      = resp;
        e.timed_out     = tmo;
        return e;
    endfunction

    // six frame bytes then the first poll
    task automatic frame_out(ref exch_t burst[$]);
        for (int i = 0; i < 6; i++)
        begin
            burst.push_back(mk_exch(m_frame[40 - 8 * i +: 8], 1'b1, 1'b0, 1'b0,
                                    8'h00, 1'b0));
        end
        burst.push_back(mk_exch(IDLE_BYTE, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0));
        m_polls = 1;
    endtask

    task automatic engine_predict(input host_req_t it);
        exch_t             burst[$];
        logic [BYTE_W-1:0] cmd;
        logic [BYTE_W-1:0] b;
        logic [6:0]        crc;
        int unsigned       lim;
        if (it.operation == OP_ISSUE)
        begin
            cmd = CMD_BASE | BYTE_W'(it.command_index);
            crc = crc7_next(7'd0, cmd);
            for (int k = 3; k >= 0; k--)
            begin
                crc = crc7_next(crc, it.argument[8 * k +: 8]);
            end
            m_frame    = {cmd, it.argument, crc, 1'b1};
            m_release  = it.release_after;
            m_attempts = '0;
            m_busy     = 1'b1;
            frame_out(burst);
        end
        else if (m_busy)
        begin
            b = it.received_byte;
            if (b[R1_BUSY_BIT] && m_polls < POLL_LIMIT)
            begin
                burst.push_back(mk_exch(IDLE_BYTE, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0));
                m_polls++;
            end
            else if (m_release)
            begin
                lim = (m_retry_limit == 0) ? 1 : int'(m_retry_limit);
                burst.push_back(mk_exch(IDLE_BYTE, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0));
                if (b[R1_CRC_ERR_BIT] && int'(m_attempts) + 1 < lim)
                begin
                    m_attempts = m_attempts + 1'b1;
                    frame_out(burst);
                end
                else
                begin
                    if (b[R1_CRC_ERR_BIT])
                    begin
                        m_attempts = m_attempts + 1'b1;
                    end
                    burst.push_back(mk_exch(8'h00, 1'b0, 1'b0, 1'b1, b, b[R1_BUSY_BIT]));
                    m_busy = 1'b0;
                end
            end
            else
            begin
                burst.push_back(mk_exch(8'h00, 1'b1, 1'b0, 1'b1, b, b[R1_BUSY_BIT]));
                m_busy = 1'b0;
            end
        end
        if (burst.size() > 0)
        begin
            burst[burst.size() - 1].last = 1'b1;
            taken_items++;
        end
        foreach (burst[i])
        begin
            pending_exch.push_back(burst[i]);
        end
    endtask

    // ------------------------------------------------------------------
    // result monitor
    // ------------------------------------------------------------------
    function automatic string exch_str(input exch_t e);
        return $sformatf("tx=%02h sel=%0b rep=%0b last=%0b done=%0b resp=%02h tmo=%0b",
                         e.tx_byte, e.select_active, e.expect_reply, e.last,
                         e.done_res, e.response, e.timed_out);
    endfunction

    always @(posedge clk)
    begin : rsp_monitor
        exch_t got;
        exch_t want;
        if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
        begin
            got.tx_byte       = rsp.tx_byte;
            got.select_active = rsp.select_active;
            got.expect_reply  = rsp.expect_reply;
            got.last          = rsp.last;
            got.done_res      = rsp.done_res;
            got.response      = rsp.response;
            got.timed_out     = rsp.timed_out;
            if (pending_exch.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                begin
                    $display("cycle %0d: transfer with nothing expected: %s",
                             cycle_count, exch_str(got));
                end
            end
            else
            begin
                want = pending_exch.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                    begin
                        $display("cycle %0d: transfer mismatch", cycle_count);
                        $display("  expected %s", exch_str(want));
                        $display("  actual   %s", exch_str(got));
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // sink side: ready with random stall bursts
    // ------------------------------------------------------------------
    initial
    begin : rsp_sink
        int unsigned stall_left;
        stall_left = 0;
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                rsp.ready <= 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 7);
                rsp.ready <= 1'b0;
            end
            else
            begin
                rsp.ready <= 1'b1;
            end
        end
    end

    // watchdog on a hung handshake or a lost transfer
    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[sd_spi_command_engine_top] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // unused fields of an item carry random values
    function automatic host_req_t issue_item(input logic [CMD_IDX_W-1:0] idx,
                                             input logic [ARG_W-1:0] arg,
                                             input logic rel);
        host_req_t it;
        it.operation     = OP_ISSUE;
        it.command_index = idx;
        it.argument      = arg;
        it.release_after = rel;
        it.received_byte = BYTE_W'($urandom);
        return it;
    endfunction

    function automatic host_req_t poll_item(input logic [BYTE_W-1:0] b);
        host_req_t it;
        it.operation     = OP_POLL;
        it.command_index = CMD_IDX_W'($urandom);
        it.argument      = $urandom;
        it.release_after = 1'($urandom);
        it.received_byte = b;
        return it;
    endfunction

    function automatic logic [BYTE_W-1:0] busy_byte();
        return {1'b1, 7'($urandom)};
    endfunction

    function automatic logic [BYTE_W-1:0] final_byte();
        return {1'b0, 7'($urandom)};
    endfunction

    // one request transfer, with an optional idle burst in front
    task automatic send_item(input host_req_t it);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        req.valid         <= 1'b1;
        req.operation     <= it.operation;
        req.command_index <= it.command_index;
        req.argument      <= it.argument;
        req.release_after <= it.release_after;
        req.received_byte <= it.received_byte;
        @(posedge clk);
        while (req.ready !== 1'b1)
        begin
            @(posedge clk);
        end
        engine_predict(it);
    endtask

    // hold the source until every owed transfer has arrived, then let the
    // engine settle in case the last item caused nothing
    task automatic wait_quiet();
        req.valid <= 1'b0;
        while (pending_exch.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write, only ever called right after wait_quiet
    task automatic set_retry_limit(input logic [RETRY_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        m_retry_limit = v;
    endtask

    // a full command with random content: issue, some busy polls and a
    // final byte per attempt; a new issue now and then cuts it short
    task automatic run_command(input bit allow_break);
        int unsigned busy_run;
        send_item(issue_item(CMD_IDX_W'($urandom), $urandom, 1'($urandom)));
        while (m_busy)
        begin
            busy_run = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12)
                                                   : $urandom_range(0, 2);
            repeat (busy_run) send_item(poll_item(busy_byte()));
            if (allow_break && $urandom_range(0, 15) == 0)
            begin
                send_item(issue_item(CMD_IDX_W'($urandom), $urandom, 1'($urandom)));
            end
            else
            begin
                send_item(poll_item(final_byte()));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // field extremes, both operations and the named corner cases, at the
    // reset retry limit
    task automatic test_directed();
        // plain command, lowest index and argument, two busy polls
        send_item(issue_item(6'd0, 32'h0000_0000, 1'b0));
        send_item(poll_item(8'h80));
        send_item(poll_item(8'hFF));
        send_item(poll_item(8'h00));
        // highest index and argument under release, crc error then success
        send_item(issue_item(6'd63, 32'hFFFF_FFFF, 1'b1));
        send_item(poll_item(8'h7F));
        send_item(poll_item(8'h00));
        // poll bytes while idle are dropped
        send_item(poll_item(8'h00));
        send_item(poll_item(8'hFF));
        // issue while busy abandons the running command
        send_item(issue_item(6'd17, 32'h1234_5678, 1'b0));
        send_item(poll_item(8'h80));
        send_item(issue_item(6'd24, 32'hA5A5_A5A5, 1'b1));
        send_item(poll_item(8'h05));
        // crc error without release: reported, card stays selected
        send_item(issue_item(6'd55, 32'h8000_0001, 1'b0));
        send_item(poll_item(8'h08));
        // illegal command r1 under release
        send_item(issue_item(6'd8, 32'h0000_01AA, 1'b1));
        send_item(poll_item(8'h04));
    endtask

    // exhaust the retries at several limits, zero counting as one attempt
    task automatic test_retry_limits();
        logic [RETRY_W-1:0] limits[4];
        limits[0] = 4'd0;
        limits[1] = 4'd1;
        limits[2] = 4'd15;
        limits[3] = RETRY_W'($urandom_range(2, 14));
        foreach (limits[i])
        begin
            wait_quiet();
            set_retry_limit(limits[i]);
            send_item(issue_item(CMD_IDX_W'($urandom), $urandom, 1'b1));
            while (m_busy)
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    send_item(poll_item(busy_byte()));
                end
                // every attempt ends in a crc error
                send_item(poll_item(final_byte() | 8'h08));
            end
        end
    endtask

    // random commands with noise, broken sequences, register changes and
    // full pauses of the source
    task automatic test_random_traffic();
        int unsigned start;
        logic [RETRY_W-1:0] v;
        start = taken_items;
        while (taken_items - start < RANDOM_ITEMS)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0)
            begin
                wait_quiet();
                case ($urandom_range(0, 3))
                    0: v = 4'd0;
                    1: v = 4'd1;
                    2: v = 4'd15;
                    default: v = RETRY_W'($urandom);
                endcase
                set_retry_limit(v);
            end
            if (!m_busy && $urandom_range(0, 11) == 0)
            begin
                send_item(poll_item(BYTE_W'($urandom)));
            end
            run_command(1'b1);
        end
    endtask

    // last stretch with ready held high and no source gaps
    task automatic test_full_rate();
        int unsigned start;
        gaps_on = 1'b0;
        start = taken_items;
        while (taken_items - start < FULL_RATE_ITEMS)
        begin
            run_command(1'b0);
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        mismatches  = 0;
        taken_items = 0;
        gaps_on     = 1'b1;

        m_retry_limit = RETRY_RESET;
        m_frame       = '0;
        m_attempts    = '0;
        m_polls       = 0;
        m_release     = 1'b0;
        m_busy        = 1'b0;

        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_wdata         <= '0;
        req.valid         <= 1'b0;
        req.operation     <= OP_ISSUE;
        req.command_index <= '0;
        req.argument      <= '0;
        req.release_after <= 1'b0;
        req.received_byte <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_retry_limits();
        test_random_traffic();
        test_full_rate();

        wait_quiet();
        if (mismatches == 0)
        begin
            $display("[sd_spi_command_engine_top] OK");
        end
        else
        begin
            $display("[sd_spi_command_engine_top] ERROR");
        end
        $finish;
    end

endmodule
